FILE: hdl/color_minmax_normalizer_top_defines.svh
// assertion macros for the color min/max normalizer
`ifndef COLOR_MINMAX_NORMALIZER_TOP_DEFINES_SVH
`define COLOR_MINMAX_NORMALIZER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CMN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cmn_pkg.sv
// shared constants, types and helpers of the color min/max normalizer
`timescale 1ns / 1ps

package cmn_pkg;

  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned STEP_W      = $clog2(SAMPLE_BITS);

  typedef logic [SAMPLE_BITS-1:0] level_t;
  typedef level_t [CHANNELS-1:0] level_vec_t;

  localparam level_t FULL_SCALE = {SAMPLE_BITS{1'b1}};

  typedef struct packed {
    level_t clear_level;
    level_t red_level;
    level_t green_level;
    level_t blue_level;
  } cmn_sample_t;

  typedef struct packed {
    level_t                clear_norm;
    level_t                red_norm;
    level_t                green_norm;
    level_t                blue_norm;
    logic [CHANNELS-1:0]   flat_mask;
  } cmn_result_t;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                prime;
    logic                update;
    logic                ch_start;
    logic                div_step;
    logic                mult;
    logic                publish;
    logic [CH_IDX_W-1:0] ch_idx;
  } cmn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } cmn_status_t;

  // channel order: clear, red, green, blue
  function automatic level_vec_t to_levels(cmn_sample_t s);
    level_vec_t v;
    v[0] = s.clear_level;
    v[1] = s.red_level;
    v[2] = s.green_level;
    v[3] = s.blue_level;
    return v;
  endfunction

  function automatic cmn_result_t to_result(level_vec_t n, logic [CHANNELS-1:0] f);
    cmn_result_t r;
    r.clear_norm = n[0];
    r.red_norm   = n[1];
    r.green_norm = n[2];
    r.blue_norm  = n[3];
    r.flat_mask  = f;
    return r;
  endfunction

endpackage

FILE: hdl/cmn_if.sv
// valid/ready stream interfaces for samples and results
`timescale 1ns / 1ps

interface cmn_sample_if;
  import cmn_pkg::*;
  logic        valid;
  logic        ready;
  cmn_sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmn_result_if;
  import cmn_pkg::*;
  logic        valid;
  logic        ready;
  cmn_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/color_minmax_normalizer_top.sv
// a primed sample updates min/max, then each channel is normalized; the priming sample gives none
// one shared radix-2 divider (16 steps per channel); no new sample until the result is handed off
// each channel runs span setup, 16 divide steps and one multiply, after the min/max update
// reset: rst_ni low clears the primed flag, the state machine and the output valid
// min/max registers hold no reset value; the first sample after reset loads them
`timescale 1ns / 1ps
`include "color_minmax_normalizer_top_defines.svh"

module color_minmax_normalizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmn_sample_if.sink    sample_i,
  cmn_result_if.source  result_o
);
  import cmn_pkg::*;

  // command and status between the sequencer and the datapath
  cmn_cmd_t    cmd;
  cmn_status_t status;

  // datapath operations gathered for the overlap check
  logic [5:0]  cmd_ops;

  // sequencer: priming, min/max update, per-channel divide and multiply, result hand-off
  cmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: the result register lets a new sample transfer in while a result waits
  cmn_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (sample_i.data),
    .res_ready_i (result_o.ready),
    .status_o    (status),
    .result_o    (result_o.data),
    .res_valid_o (result_o.valid)
  );

  assign cmd_ops = {cmd.load, cmd.update, cmd.ch_start, cmd.div_step, cmd.mult, cmd.publish};

  // a result is only written into a free output register
  `CMN_ASSERT_SAME(a_publish_free, cmd.publish, status.out_free, "result overwritten")

  // the datapath gets at most one operation per cycle
  `CMN_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd_ops), "overlapping datapath commands")

  // the multiply always follows the last divide step
  `CMN_ASSERT_NEXT(a_div_then_mult, cmd.div_step, cmd.div_step || cmd.mult, "divide sequence broken")

endmodule

FILE: hdl/cmn_ctrl.sv
// sequencing state machine of the normalizer
`timescale 1ns / 1ps

module cmn_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cmn_pkg::cmn_status_t  status_i,
  output cmn_pkg::cmn_cmd_t     cmd_o
);
  import cmn_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_MULT   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  localparam logic [CH_IDX_W-1:0] LAST_CH   = CH_IDX_W'(CHANNELS - 1);
  localparam logic [STEP_W-1:0]   LAST_STEP = STEP_W'(SAMPLE_BITS - 1);

  logic [2:0]          state_q, state_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                primed_q, primed_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    step_d       = step_q;
    primed_d     = primed_q;
    cmd_o        = '0;
    cmd_o.ch_idx = ch_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.prime = !primed_q;
          primed_d    = 1'b1;
          if (primed_q) begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        ch_d         = '0;
        state_d      = ST_START;
      end
      ST_START: begin
        cmd_o.ch_start = 1'b1;
        step_d         = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        if (ch_q == LAST_CH) begin
          state_d = ST_EMIT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_START;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ch_q     <= '0;
      step_q   <= '0;
      primed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ch_q     <= ch_d;
      step_q   <= step_d;
      primed_q <= primed_d;
    end
  end

endmodule

FILE: hdl/cmn_datapath.sv
// min/max store, serial divider, scaling multiplier and result register
`timescale 1ns / 1ps

module cmn_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmn_pkg::cmn_cmd_t     cmd_i,
  input  cmn_pkg::cmn_sample_t  sample_i,
  input  logic                  res_ready_i,
  output cmn_pkg::cmn_status_t  status_o,
  output cmn_pkg::cmn_result_t  result_o,
  output logic                  res_valid_o
);
  import cmn_pkg::*;

  level_vec_t            in_vec;
  level_vec_t            lvl_q, low_q, high_q, norm_q;
  logic [CHANNELS-1:0]   flat_q;
  level_t                span_q, diff_q, rem_q, dvd_q;
  logic [SAMPLE_BITS:0]  trial, sub;
  logic                  fits;
  logic [2*SAMPLE_BITS-1:0] prod;
  cmn_result_t           res_q;
  logic                  res_valid_q;

  assign in_vec = to_levels(sample_i);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[SAMPLE_BITS-1]};
    sub   = trial - {1'b0, span_q};
    fits  = (trial >= {1'b0, span_q});
    prod  = diff_q * dvd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lvl_q <= in_vec;
      if (cmd_i.prime) begin
        low_q  <= in_vec;
        high_q <= in_vec;
      end
    end
    if (cmd_i.update) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (lvl_q[c] < low_q[c]) begin
          low_q[c] <= lvl_q[c];
        end
        if (lvl_q[c] > high_q[c]) begin
          high_q[c] <= lvl_q[c];
        end
      end
    end
    if (cmd_i.ch_start) begin
      span_q               <= high_q[cmd_i.ch_idx] - low_q[cmd_i.ch_idx];
      diff_q               <= lvl_q[cmd_i.ch_idx] - low_q[cmd_i.ch_idx];
      flat_q[cmd_i.ch_idx] <= (high_q[cmd_i.ch_idx] == low_q[cmd_i.ch_idx]);
      rem_q                <= '0;
      dvd_q                <= FULL_SCALE;
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      dvd_q <= {dvd_q[SAMPLE_BITS-2:0], fits};
    end
    if (cmd_i.mult) begin
      // quotient sits in dvd_q; zero range forces zero
      norm_q[cmd_i.ch_idx] <= flat_q[cmd_i.ch_idx] ? '0 : prod[SAMPLE_BITS-1:0];
    end
    if (cmd_i.publish) begin
      res_q <= to_result(norm_q, flat_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !res_valid_q || res_ready_i;
  assign result_o          = res_q;
  assign res_valid_o       = res_valid_q;

endmodule

FILE: tb/tb.sv
// testbench for the color min/max normalizer: directed table, then random samples
`timescale 1ns / 1ps

module tb;
  import cmn_pkg::*;

  // one row of the directed table; want holds a hand-worked result where typed is set
  typedef struct {
    cmn_sample_t s;
    bit          typed;
    bit          yields;
    cmn_result_t want;
  } dir_row_t;

  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic clk_i;
  logic rst_ni;

  cmn_sample_if sample_if ();
  cmn_result_if result_if ();

  color_minmax_normalizer_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  // running range tracked on the testbench side
  bit          primed;
  level_t      ch_lo [CHANNELS];
  level_t      ch_hi [CHANNELS];
  cmn_result_t norm_q [$];

  int unsigned fail_cnt;
  int unsigned send_pct;
  int unsigned recv_pct;
  bit          hold_req;
  bit          hold_done;

  // clock, 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // reset once, released on a rising edge
  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // all inputs known from time zero
  initial begin
    sample_if.valid  <= 1'b0;
    sample_if.data   <= '0;
    result_if.ready  <= 1'b0;
  end

  // widen the range, then scale each channel by floor(full/span);
  // the priming sample only loads the range and gives nothing
  function automatic bit predict_norm(input cmn_sample_t s, output cmn_result_t r);
    level_t              lv [CHANNELS];
    level_t              nv [CHANNELS];
    logic [CHANNELS-1:0] flat;
    level_t              span;
    level_t              scale;
    logic [31:0]         prod;
    lv[0] = s.clear_level;
    lv[1] = s.red_level;
    lv[2] = s.green_level;
    lv[3] = s.blue_level;
    r     = '0;
    flat  = '0;
    if (!primed) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ch_lo[c] = lv[c];
        ch_hi[c] = lv[c];
      end
      primed = 1'b1;
      return 1'b0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      if (lv[c] < ch_lo[c]) ch_lo[c] = lv[c];
      if (lv[c] > ch_hi[c]) ch_hi[c] = lv[c];
    end
    for (int c = 0; c < CHANNELS; c++) begin
      span = ch_hi[c] - ch_lo[c];
      if (span == '0) begin
        // zero range: no division, flag the channel
        flat[c] = 1'b1;
        nv[c]   = '0;
      end else begin
        scale = FULL_SCALE / span;
        prod  = 32'(lv[c] - ch_lo[c]) * 32'(scale);
        nv[c] = prod[SAMPLE_BITS-1:0];
      end
    end
    r.clear_norm = nv[0];
    r.red_norm   = nv[1];
    r.green_norm = nv[2];
    r.blue_norm  = nv[3];
    r.flat_mask  = flat;
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(level_t c, level_t rd, level_t g, level_t b,
                                      bit typed, bit yields,
                                      level_t ec, level_t er, level_t eg, level_t eb,
                                      logic [CHANNELS-1:0] em);
    dir_row_t row;
    row.s.clear_level = c;
    row.s.red_level   = rd;
    row.s.green_level = g;
    row.s.blue_level  = b;
    row.typed         = typed;
    row.yields        = yields;
    row.want.clear_norm = ec;
    row.want.red_norm   = er;
    row.want.green_norm = eg;
    row.want.blue_norm  = eb;
    row.want.flat_mask  = em;
    return row;
  endfunction

  // random level for one channel: mostly inside the current range,
  // sometimes on its edges, sometimes a step outside that grows with k
  function automatic level_t pick_level(int ch, int k);
    int unsigned r;
    int          v;
    int          stride;
    r      = $urandom_range(99);
    stride = $urandom_range(1 + 2 * k, 1);
    if (r < 70) begin
      v = int'($urandom_range(ch_hi[ch], ch_lo[ch]));
    end else if (r < 80) begin
      v = $urandom_range(1) ? int'(ch_hi[ch]) : int'(ch_lo[ch]);
    end else if (r < 90) begin
      v = int'(ch_lo[ch]) - stride;
      if (v < 0) v = 0;
    end else begin
      v = int'(ch_hi[ch]) + stride;
      if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
    end
    return level_t'(v);
  endfunction

  // offer one sample, with a random gap before it; update the prediction at transfer
  task automatic offer(input cmn_sample_t s, input bit typed, input bit yields,
                       input cmn_result_t want);
    cmn_result_t got;
    bit          has;
    int          gap;
    gap = 0;
    while ($urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    do @(posedge clk_i); while (!sample_if.ready);
    has = predict_norm(s, got);
    if (typed) begin
      if (yields) norm_q.push_back(want);
    end else if (has) begin
      norm_q.push_back(got);
    end
  endtask

  // sender: directed table, then random samples, then drain and verdict
  initial begin
    dir_row_t    rows [$];
    cmn_sample_t s;
    cmn_result_t none;
    none      = '0;
    primed    = 1'b0;
    fail_cnt  = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    send_pct  = 29;
    recv_pct  = 69;

    // priming sample, then a repeat of it where every channel is flat
    rows.push_back(mk_row(16'h8000, 16'h1000, 16'h2000, 16'h3000, 1, 0, 0, 0, 0, 0, 4'h0));
    rows.push_back(mk_row(16'h8000, 16'h1000, 16'h2000, 16'h3000, 1, 1, 0, 0, 0, 0, 4'hF));
    // span of one gives the largest scale
    rows.push_back(mk_row(16'h8001, 16'h1000, 16'h2000, 16'h3000, 1, 1,
                          16'hFFFF, 0, 0, 0, 4'hE));
    rows.push_back(mk_row(16'h8000, 16'h1000, 16'h2000, 16'h3000, 1, 1, 0, 0, 0, 0, 4'hE));
    // clear channel opened to both extremes, scale falls to one
    rows.push_back(mk_row(16'h0000, 16'h1000, 16'h2000, 16'h3000, 1, 1, 0, 0, 0, 0, 4'hE));
    rows.push_back(mk_row(16'hFFFF, 16'h1000, 16'h2000, 16'h3000, 1, 1,
                          16'hFFFF, 0, 0, 0, 4'hE));
    rows.push_back(mk_row(16'h1234, 16'h1000, 16'h2000, 16'h3000, 1, 1,
                          16'h1234, 0, 0, 0, 4'hE));
    rows.push_back(mk_row(16'h0000, 16'h1002, 16'h2000, 16'h3000, 1, 1,
                          0, 16'hFFFE, 0, 0, 4'hC));
    rows.push_back(mk_row(16'h0000, 16'h1001, 16'h2000, 16'h3000, 1, 1,
                          0, 16'h7FFF, 0, 0, 4'hC));
    rows.push_back(mk_row(16'hFFFF, 16'h1000, 16'h2003, 16'h3000, 1, 1,
                          16'hFFFF, 0, 16'hFFFF, 0, 4'h8));
    // blue widens downward, no channel flat any more
    rows.push_back(mk_row(16'h5555, 16'h1000, 16'h2001, 16'h2FFF, 1, 1,
                          16'h5555, 0, 16'h5555, 0, 4'h0));
    rows.push_back(mk_row(16'h0000, 16'h1002, 16'h2000, 16'h3000, 1, 1,
                          0, 16'hFFFE, 0, 16'hFFFF, 4'h0));
    // odd spans, left to the predictor
    rows.push_back(mk_row(16'h7FFF, 16'h1007, 16'h2002, 16'h2FFF, 0, 0, 0, 0, 0, 0, 4'h0));
    rows.push_back(mk_row(16'h8000, 16'h0FF0, 16'h2010, 16'h3005, 0, 0, 0, 0, 0, 0, 4'h0));
    rows.push_back(mk_row(16'h0001, 16'h1003, 16'h1FFF, 16'h3001, 0, 0, 0, 0, 0, 0, 4'h0));
    rows.push_back(mk_row(16'hFFFE, 16'h0FF8, 16'h2004, 16'h3002, 0, 0, 0, 0, 0, 0, 4'h0));

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (rows[i]) offer(rows[i].s, rows[i].typed, rows[i].yields, rows[i].want);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // idling phases: sender light / receiver heavy, then swapped, then none
      if (k < 480) begin
        send_pct = 29;
        recv_pct = 69;
      end else if (k < 960) begin
        send_pct = 69;
        recv_pct = 29;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      // long receiver hold-off while samples keep coming
      if (k == 1100) hold_req = 1'b1;
      if (k >= 1300 && $urandom_range(9) == 0) begin
        // noise: any level on any channel
        s.clear_level = level_t'($urandom);
        s.red_level   = level_t'($urandom);
        s.green_level = level_t'($urandom);
        s.blue_level  = level_t'($urandom);
      end else begin
        s.clear_level = pick_level(0, k);
        s.red_level   = pick_level(1, k);
        s.green_level = pick_level(2, k);
        s.blue_level  = pick_level(3, k);
      end
      offer(s, 1'b0, 1'b0, none);
    end
    sample_if.valid <= 1'b0;

    // drain, then watch for stray results a while longer
    while (norm_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random ready, one long hold-off counted here
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // result check against the oldest expectation at each transfer
  always @(posedge clk_i) begin
    cmn_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (norm_q.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_cnt++;
      end else begin
        want = norm_q.pop_front();
        if (result_if.data.clear_norm !== want.clear_norm) begin
          $error("clear_norm expected %h actual %h", want.clear_norm,
                 result_if.data.clear_norm);
          fail_cnt++;
        end
        if (result_if.data.red_norm !== want.red_norm) begin
          $error("red_norm expected %h actual %h", want.red_norm, result_if.data.red_norm);
          fail_cnt++;
        end
        if (result_if.data.green_norm !== want.green_norm) begin
          $error("green_norm expected %h actual %h", want.green_norm,
                 result_if.data.green_norm);
          fail_cnt++;
        end
        if (result_if.data.blue_norm !== want.blue_norm) begin
          $error("blue_norm expected %h actual %h", want.blue_norm, result_if.data.blue_norm);
          fail_cnt++;
        end
        if (result_if.data.flat_mask !== want.flat_mask) begin
          $error("flat_mask expected %h actual %h", want.flat_mask, result_if.data.flat_mask);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: several times the slowest expected run
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/cmn_pkg.sv
hdl/cmn_if.sv
hdl/cmn_ctrl.sv
hdl/cmn_datapath.sv
hdl/color_minmax_normalizer_top.sv
tb/tb.sv
